>>> rtl/core/img2dc_pkg.sv
// Shared constants, types and state codes for the 2D correlation unit.
`timescale 1ns / 1ps

package img2dc_pkg;

    // Default structural sizes handed to the top level.
    localparam int DEF_MAX_KERN_WIDTH  = 8;
    localparam int DEF_MAX_KERN_HEIGHT = 8;
    localparam int DEF_MAX_PAD_WIDTH   = 1024;
    localparam int DEF_PIXEL_BITS      = 16;
    localparam int DEF_COEF_BITS       = 18;

    // Fixed field widths of the stream items.
    localparam int COEF_INDEX_BITS = 6;
    localparam int RESULT_BITS     = 32;
    localparam int OUT_ROW_BITS    = 12;
    localparam int OUT_COL_BITS    = 10;
    localparam int OUT_PAD_BITS    = 2;
    localparam int OUT_DATA_BITS   = RESULT_BITS + OUT_ROW_BITS + OUT_COL_BITS + OUT_PAD_BITS;
    localparam int IN_USER_BITS    = 2;
    localparam int USER_FUNC       = 0;
    localparam int USER_FIRST      = 1;
    localparam int IN_ROW_BITS     = 13;

    // Item kinds carried in the func bit.
    localparam logic FUNC_COEF  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Configuration port layout.
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 13;
    localparam int PAD_WIDTH_BITS  = 11;
    localparam int OUT_WIDTH_BITS  = 11;
    localparam int KERN_DIM_BITS   = 4;
    localparam int ROW_START_BITS  = 12;
    localparam int ROW_END_BITS    = 13;
    localparam int FRAC_BITS_BITS  = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAD_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KERN_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KERN_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_START   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_END     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAC_BITS   = 3'd6;

    // Register values after reset.
    localparam int PAD_WIDTH_RST   = 1024;
    localparam int OUT_WIDTH_RST   = 1017;
    localparam int KERN_WIDTH_RST  = 8;
    localparam int KERN_HEIGHT_RST = 8;
    localparam int ROW_START_RST   = 0;
    localparam int ROW_END_RST     = 4096;
    localparam int FRAC_BITS_RST   = 16;

    // Saturation limits of the result.
    localparam logic [RESULT_BITS-1:0] RESULT_MAX = 32'h7FFF_FFFF;
    localparam logic [RESULT_BITS-1:0] RESULT_MIN = 32'h8000_0000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_SCALE,
        ST_SATUR,
        ST_PUSH
    } t_state;

    // Commands from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic tap;
        logic shift;
        logic sat;
    } t_mac_ctl;

endpackage

>>> rtl/core/image_2d_correlation_unit.sv
// Top level of the valid-mode 2D correlation unit: stream ports, sequencer and stores.
//
//  Port group     | Dir | Transfer contents
//  ---------------+-----+-------------------------------------------------------------
//  i_cfg_*        | in  | register write: index, data (no handshake, one per cycle)
//  s_axis_*       | in  | coefficient or pixel item; tuser = func, first_pixel
//  m_axis_*       | out | one result per completed, selected window; tuser = saturated
//
// A coefficient item, or a pixel that completes no selected window, is taken while idle.
// A pixel that completes a selected window starts a walk over the kern_width * kern_height
// taps: the shared multiply-accumulate unit steps through them one per cycle, reading one
// line-store word and one coefficient per cycle, then drains, scales, clips and pushes.
// Reset is synchronous and active low; the stores are not cleared.
// While a finished result waits on m_axis_tready, new items are still taken; only the
// next result waits for the output register to free up.
`timescale 1ns / 1ps

module image_2d_correlation_unit #(
    parameter int MAX_KERN_WIDTH  = img2dc_pkg::DEF_MAX_KERN_WIDTH,
    parameter int MAX_KERN_HEIGHT = img2dc_pkg::DEF_MAX_KERN_HEIGHT,
    parameter int MAX_PAD_WIDTH   = img2dc_pkg::DEF_MAX_PAD_WIDTH,
    parameter int PIXEL_BITS      = img2dc_pkg::DEF_PIXEL_BITS,
    parameter int COEF_BITS       = img2dc_pkg::DEF_COEF_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_wen,
    input  logic [img2dc_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [img2dc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Input items.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata from bit 0: coef_index, coef_value, pixel, zero fill to whole bytes
    input  logic [((img2dc_pkg::COEF_INDEX_BITS + COEF_BITS + PIXEL_BITS + 7) / 8) * 8 - 1:0]
                                                   s_axis_tdata,
    // tuser from bit 0: func, first_pixel
    input  logic [img2dc_pkg::IN_USER_BITS-1:0]    s_axis_tuser,
    // Results.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata from bit 0: result, out_row, out_col, zero fill
    output logic [img2dc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // tuser from bit 0: saturated
    output logic                                   m_axis_tuser
);
    import img2dc_pkg::*;

    // Store geometry and counter widths.
    localparam int COEF_DEPTH = MAX_KERN_WIDTH * MAX_KERN_HEIGHT;
    localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int LINE_DEPTH = MAX_KERN_HEIGHT * MAX_PAD_WIDTH;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_PAD_WIDTH);
    localparam int PW_W       = $clog2(MAX_PAD_WIDTH + 1);
    localparam int KW_W       = $clog2(MAX_KERN_WIDTH + 1);
    localparam int KH_W       = $clog2(MAX_KERN_HEIGHT + 1);
    localparam int KC_W       = (MAX_KERN_WIDTH > 1) ? $clog2(MAX_KERN_WIDTH) : 1;
    localparam int SLOT_W     = (MAX_KERN_HEIGHT > 1) ? $clog2(MAX_KERN_HEIGHT) : 1;

    // Accumulator holds every window sum exactly and one bit beyond the result.
    localparam int ACC_RAW  = PIXEL_BITS + COEF_BITS + $clog2(COEF_DEPTH);
    localparam int ACC_BITS = (ACC_RAW > RESULT_BITS) ? ACC_RAW : RESULT_BITS + 1;

    // Input field positions in tdata.
    localparam int CV_LSB = COEF_INDEX_BITS;
    localparam int PX_LSB = COEF_INDEX_BITS + COEF_BITS;

    // Reset values clipped to the supported sizes.
    localparam int PW_RST = (PAD_WIDTH_RST > MAX_PAD_WIDTH) ? MAX_PAD_WIDTH : PAD_WIDTH_RST;
    localparam int KW_RST = (KERN_WIDTH_RST > MAX_KERN_WIDTH) ? MAX_KERN_WIDTH : KERN_WIDTH_RST;
    localparam int KH_RST = (KERN_HEIGHT_RST > MAX_KERN_HEIGHT) ? MAX_KERN_HEIGHT
                                                                : KERN_HEIGHT_RST;

    // Configuration registers; pad width and kernel sizes are stored already clamped.
    logic [PW_W-1:0]           r_pw,  n_pw;
    logic [OUT_WIDTH_BITS-1:0] r_ow;
    logic [KW_W-1:0]           r_kw,  n_kw;
    logic [KH_W-1:0]           r_kh,  n_kh;
    logic [ROW_START_BITS-1:0] r_rs;
    logic [ROW_END_BITS-1:0]   r_re;
    logic [FRAC_BITS_BITS-1:0] r_fb;

    // Input position counters.
    logic [COL_W-1:0]       r_in_col,  n_in_col;
    logic [IN_ROW_BITS-1:0] r_in_row,  n_in_row;
    logic [SLOT_W-1:0]      r_in_slot, n_in_slot;

    // Tap sequencer.
    t_state                 r_state, n_state;
    logic [KC_W-1:0]        r_c;
    logic [SLOT_W-1:0]      r_r;
    logic [SLOT_W-1:0]      r_slot;
    logic [COL_W-1:0]       r_col0;
    logic [IN_ROW_BITS-1:0] r_row0;
    logic                   r_tap_d;
    logic                   r_drain;

    // Output register.
    logic                     r_m_valid;
    logic [OUT_DATA_BITS-1:0] r_m_data;
    logic                     r_m_user;

    // Decoded input fields.
    logic                        in_func;
    logic                        in_first;
    logic [COEF_INDEX_BITS-1:0]  in_cidx;
    logic [COEF_BITS-1:0]        in_cval;
    logic [PIXEL_BITS-1:0]       in_pix;

    // Accept-time window arithmetic.
    logic [COL_W-1:0]       col_eff;
    logic [IN_ROW_BITS-1:0] row_eff;
    logic [SLOT_W-1:0]      slot_eff;
    logic [COL_W-1:0]       col0;
    logic [IN_ROW_BITS-1:0] row0;
    logic [SLOT_W-1:0]      slot0;
    logic                   win_hit;
    logic                   emit;
    logic                   last_tap;

    // Control toward stores and arithmetic.
    logic                   accept;
    logic                   line_we;
    logic                   coef_we;
    logic                   issue;
    logic                   load_out;
    t_mac_ctl               mac_ctl;
    logic [LINE_AW-1:0]     line_waddr;
    logic [LINE_AW-1:0]     line_raddr;
    logic [COEF_AW-1:0]     coef_waddr;
    logic [COEF_AW-1:0]     coef_raddr;
    logic [PIXEL_BITS-1:0]  line_rdata;
    logic [COEF_BITS-1:0]   coef_rdata;
    logic [RESULT_BITS-1:0] mac_result;
    logic                   mac_sat;

    assign in_func  = s_axis_tuser[USER_FUNC];
    assign in_first = s_axis_tuser[USER_FIRST];
    assign in_cidx  = s_axis_tdata[CV_LSB-1:0];
    assign in_cval  = s_axis_tdata[CV_LSB +: COEF_BITS];
    assign in_pix   = s_axis_tdata[PX_LSB +: PIXEL_BITS];

    assign accept = s_axis_tvalid && s_axis_tready;

    // Clamp kernel and row sizes on their way into the registers.
    always_comb begin
        n_pw = PW_W'(i_cfg_data[PAD_WIDTH_BITS-1:0]);
        if (i_cfg_data[PAD_WIDTH_BITS-1:0] == '0) begin
            n_pw = PW_W'(1);
        end else if (int'(i_cfg_data[PAD_WIDTH_BITS-1:0]) > MAX_PAD_WIDTH) begin
            n_pw = PW_W'(MAX_PAD_WIDTH);
        end
        n_kw = KW_W'(i_cfg_data[KERN_DIM_BITS-1:0]);
        if (i_cfg_data[KERN_DIM_BITS-1:0] == '0) begin
            n_kw = KW_W'(1);
        end else if (int'(i_cfg_data[KERN_DIM_BITS-1:0]) > MAX_KERN_WIDTH) begin
            n_kw = KW_W'(MAX_KERN_WIDTH);
        end
        n_kh = KH_W'(i_cfg_data[KERN_DIM_BITS-1:0]);
        if (i_cfg_data[KERN_DIM_BITS-1:0] == '0) begin
            n_kh = KH_W'(1);
        end else if (int'(i_cfg_data[KERN_DIM_BITS-1:0]) > MAX_KERN_HEIGHT) begin
            n_kh = KH_W'(MAX_KERN_HEIGHT);
        end
    end

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw <= PW_W'(PW_RST);
            r_ow <= OUT_WIDTH_BITS'(OUT_WIDTH_RST);
            r_kw <= KW_W'(KW_RST);
            r_kh <= KH_W'(KH_RST);
            r_rs <= ROW_START_BITS'(ROW_START_RST);
            r_re <= ROW_END_BITS'(ROW_END_RST);
            r_fb <= FRAC_BITS_BITS'(FRAC_BITS_RST);
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_PAD_WIDTH:   r_pw <= n_pw;
                CFG_OUT_WIDTH:   r_ow <= i_cfg_data[OUT_WIDTH_BITS-1:0];
                CFG_KERN_WIDTH:  r_kw <= n_kw;
                CFG_KERN_HEIGHT: r_kh <= n_kh;
                CFG_ROW_START:   r_rs <= i_cfg_data[ROW_START_BITS-1:0];
                CFG_ROW_END:     r_re <= i_cfg_data[ROW_END_BITS-1:0];
                CFG_FRAC_BITS:   r_fb <= i_cfg_data[FRAC_BITS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Position of the incoming pixel and the window it completes.
    always_comb begin
        if (in_first) begin
            col_eff  = '0;
            row_eff  = '0;
            slot_eff = '0;
        end else begin
            col_eff  = (int'(r_in_col) >= int'(r_pw)) ? '0 : r_in_col;
            row_eff  = r_in_row;
            slot_eff = r_in_slot;
        end

        win_hit = (int'(col_eff) + 1 >= int'(r_kw)) && (int'(row_eff) + 1 >= int'(r_kh));
        col0    = COL_W'(int'(col_eff) + 1 - int'(r_kw));
        row0    = IN_ROW_BITS'(int'(row_eff) + 1 - int'(r_kh));
        emit    = win_hit && (int'(col0) < int'(r_ow)) &&
                  (int'(row0) >= int'(r_rs)) && (int'(row0) < int'(r_re));

        // Line slot of the window's top row, modulo the line count.
        if (int'(slot_eff) >= int'(r_kh) - 1) begin
            slot0 = SLOT_W'(int'(slot_eff) - int'(r_kh) + 1);
        end else begin
            slot0 = SLOT_W'(int'(slot_eff) + MAX_KERN_HEIGHT - int'(r_kh) + 1);
        end

        // Advance to the next raster position.
        if (int'(col_eff) + 1 >= int'(r_pw)) begin
            n_in_col = '0;
            n_in_row = row_eff + 1'b1;
            if ((&row_eff) || (int'(slot_eff) == MAX_KERN_HEIGHT - 1)) begin
                n_in_slot = '0;
            end else begin
                n_in_slot = slot_eff + 1'b1;
            end
        end else begin
            n_in_col  = col_eff + 1'b1;
            n_in_row  = row_eff;
            n_in_slot = slot_eff;
        end
    end

    assign last_tap = (int'(r_c) == int'(r_kw) - 1) && (int'(r_r) == int'(r_kh) - 1);

    // Store addresses.
    assign line_waddr = LINE_AW'(int'(slot_eff) * MAX_PAD_WIDTH + int'(col_eff));
    assign line_raddr = LINE_AW'(int'(r_slot) * MAX_PAD_WIDTH + int'(r_col0) + int'(r_c));
    assign coef_waddr = COEF_AW'(in_cidx);
    assign coef_raddr = COEF_AW'(int'(r_r) * MAX_KERN_WIDTH + int'(r_c));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        line_we       = 1'b0;
        coef_we       = 1'b0;
        issue         = 1'b0;
        load_out      = 1'b0;
        mac_ctl       = '0;
        mac_ctl.tap   = r_tap_d;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                mac_ctl.clear = 1'b1;
                if (s_axis_tvalid) begin
                    if (in_func == FUNC_COEF) begin
                        coef_we = int'(in_cidx) < COEF_DEPTH;
                    end else begin
                        line_we = 1'b1;
                        if (emit) begin
                            n_state = ST_TAPS;
                        end
                    end
                end
            end
            ST_TAPS: begin
                issue = 1'b1;
                if (last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                mac_ctl.shift = 1'b1;
                n_state       = ST_SATUR;
            end
            ST_SATUR: begin
                mac_ctl.sat = 1'b1;
                n_state     = ST_PUSH;
            end
            ST_PUSH: begin
                if (!r_m_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Position counters and tap counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_slot <= '0;
            r_c       <= '0;
            r_r       <= '0;
            r_slot    <= '0;
            r_tap_d   <= 1'b0;
            r_drain   <= 1'b0;
        end else begin
            r_tap_d <= issue;
            r_drain <= (r_state == ST_DRAIN) && !r_drain;
            if (accept && (in_func == FUNC_PIXEL)) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_in_slot <= n_in_slot;
                r_c       <= '0;
                r_r       <= '0;
                r_slot    <= slot0;
            end else if (issue) begin
                if (int'(r_c) == int'(r_kw) - 1) begin
                    r_c <= '0;
                    r_r <= r_r + 1'b1;
                    if (int'(r_slot) == MAX_KERN_HEIGHT - 1) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
        end
    end

    // Window origin kept for the result item.
    always_ff @(posedge i_clk) begin
        if (accept && (in_func == FUNC_PIXEL)) begin
            r_col0 <= col0;
            r_row0 <= row0;
        end
    end

    // Output register: the held result stays until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (load_out) begin
            r_m_data <= {{OUT_PAD_BITS{1'b0}}, OUT_COL_BITS'(r_col0),
                         r_row0[OUT_ROW_BITS-1:0], mac_result};
            r_m_user <= mac_sat;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // Circular line store, one row per slot.
    img2dc_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (LINE_DEPTH),
        .AW    (LINE_AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept && line_we),
        .i_waddr (line_waddr),
        .i_wdata (in_pix),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    // Kernel coefficient store.
    img2dc_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (COEF_DEPTH),
        .AW    (COEF_AW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (accept && coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (in_cval),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    // Shared multiply-accumulate, scale and clip.
    img2dc_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_pixel     (line_rdata),
        .i_coef      (coef_rdata),
        .i_frac_bits (r_fb),
        .o_result    (mac_result),
        .o_saturated (mac_sat)
    );

`ifndef SYNTH
    // Tap counters never step outside the kernel in use.
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAPS) |-> (int'(r_c) < int'(r_kw)) && (int'(r_r) < int'(r_kh)))
        else $error("tap counter outside kernel");

    // Window reads stay inside the line store.
    a_line_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAPS) |-> (int'(r_slot) < MAX_KERN_HEIGHT) &&
        (int'(r_col0) + int'(r_c) < MAX_PAD_WIDTH))
        else $error("line store read outside its rows");

    // A pixel that completes a selected window starts the tap walk next cycle.
    a_window_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_func == FUNC_PIXEL) && emit) |=> (r_state == ST_TAPS) && (r_c == '0))
        else $error("window not started");
`endif

endmodule

>>> rtl/core/img2dc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module img2dc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/img2dc_mac.sv
// Shared multiply-accumulate unit with final scaling shift and saturation.
`timescale 1ns / 1ps

module img2dc_mac #(
    parameter int PIXEL_BITS = img2dc_pkg::DEF_PIXEL_BITS,
    parameter int COEF_BITS  = img2dc_pkg::DEF_COEF_BITS,
    parameter int ACC_BITS   = 40
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  img2dc_pkg::t_mac_ctl                 i_ctl,
    input  logic [PIXEL_BITS-1:0]                i_pixel,
    input  logic [COEF_BITS-1:0]                 i_coef,
    input  logic [img2dc_pkg::FRAC_BITS_BITS-1:0] i_frac_bits,
    output logic [img2dc_pkg::RESULT_BITS-1:0]   o_result,
    output logic                                 o_saturated
);
    import img2dc_pkg::*;

    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;

    logic signed [PROD_BITS-1:0]   r_prod;
    logic                          r_prod_vld;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic [RESULT_BITS-1:0]        r_result;
    logic                          r_sat;
    logic [ACC_BITS-RESULT_BITS:0] acc_hi;
    logic                          acc_ovf;

    // The bits above the result must all copy its sign bit, else it clips.
    assign acc_hi  = r_acc[ACC_BITS-1:RESULT_BITS-1];
    assign acc_ovf = !((&acc_hi) || (~|acc_hi));

    // Product register in front of the accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.tap;
        end
        r_prod <= $signed(i_pixel) * $signed(i_coef);
    end

    // Accumulator; it is also reused to hold the scaled sum.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_BITS'(r_prod);
        end else if (i_ctl.shift) begin
            r_acc <= r_acc >>> i_frac_bits;
        end
    end

    // Clip the scaled sum to the signed result range.
    always_ff @(posedge i_clk) begin
        if (i_ctl.sat) begin
            r_sat <= acc_ovf;
            if (acc_ovf) begin
                r_result <= r_acc[ACC_BITS-1] ? RESULT_MIN : RESULT_MAX;
            end else begin
                r_result <= r_acc[RESULT_BITS-1:0];
            end
        end
    end

    assign o_result    = r_result;
    assign o_saturated = r_sat;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the 2D correlation unit: stream stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module tb;
    import img2dc_pkg::*;

    localparam int IN_DATA_BITS =
        ((COEF_INDEX_BITS + DEF_COEF_BITS + DEF_PIXEL_BITS + 7) / 8) * 8;
    localparam int KERN_TAPS     = DEF_MAX_KERN_WIDTH * DEF_MAX_KERN_HEIGHT;
    localparam int LINE_WORDS    = DEF_MAX_KERN_HEIGHT * DEF_MAX_PAD_WIDTH;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 1500;
    localparam int IDLE_PERCENT  = 26;
    localparam int RANDOM_ITEMS  = 900;
    localparam longint TIMEOUT_NS = 10_000_000;

    // Register index outside the register map; writes to it must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;

    typedef struct {
        logic                            func;
        logic [COEF_INDEX_BITS-1:0]      coef_index;
        logic signed [DEF_COEF_BITS-1:0] coef_value;
        logic signed [DEF_PIXEL_BITS-1:0] pixel;
        logic                            first_pixel;
    } stream_item_t;

    typedef struct {
        logic [RESULT_BITS-1:0]  value;
        logic [OUT_ROW_BITS-1:0] row;
        logic [OUT_COL_BITS-1:0] col;
        logic                    sat;
    } window_result_t;

    // Predicts window sums from accepted items and checks each result transfer in order.
    class corr_scoreboard;
        logic signed [DEF_COEF_BITS-1:0]  coef_mem [KERN_TAPS];
        logic signed [DEF_PIXEL_BITS-1:0] line_mem [LINE_WORDS];
        int unsigned in_row;
        int unsigned in_col;
        logic [PAD_WIDTH_BITS-1:0] pad_width;
        logic [OUT_WIDTH_BITS-1:0] out_width;
        logic [KERN_DIM_BITS-1:0]  kern_width;
        logic [KERN_DIM_BITS-1:0]  kern_height;
        logic [ROW_START_BITS-1:0] row_start;
        logic [ROW_END_BITS-1:0]   row_end;
        logic [FRAC_BITS_BITS-1:0] frac_bits;
        window_result_t pending_results [$];
        int mismatch_count;

        function new();
            in_row         = 0;
            in_col         = 0;
            pad_width      = PAD_WIDTH_RST;
            out_width      = OUT_WIDTH_RST;
            kern_width     = KERN_WIDTH_RST;
            kern_height    = KERN_HEIGHT_RST;
            row_start      = ROW_START_RST;
            row_end        = ROW_END_RST;
            frac_bits      = FRAC_BITS_RST;
            mismatch_count = 0;
        endfunction

        static function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_PAD_WIDTH:   pad_width   = data[PAD_WIDTH_BITS-1:0];
                CFG_OUT_WIDTH:   out_width   = data[OUT_WIDTH_BITS-1:0];
                CFG_KERN_WIDTH:  kern_width  = data[KERN_DIM_BITS-1:0];
                CFG_KERN_HEIGHT: kern_height = data[KERN_DIM_BITS-1:0];
                CFG_ROW_START:   row_start   = data[ROW_START_BITS-1:0];
                CFG_ROW_END:     row_end     = data[ROW_END_BITS-1:0];
                CFG_FRAC_BITS:   frac_bits   = data[FRAC_BITS_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        // Updates the stores and position counters for one accepted item and queues any expected result.
        function void note_item(stream_item_t it);
            int unsigned pw, kw, kh, col0, row0;
            longint acc, scaled;
            window_result_t res;
            if (it.func == FUNC_COEF) begin
                coef_mem[it.coef_index] = it.coef_value;
                return;
            end
            pw = clip(pad_width, 1, DEF_MAX_PAD_WIDTH);
            kw = clip(kern_width, 1, DEF_MAX_KERN_WIDTH);
            kh = clip(kern_height, 1, DEF_MAX_KERN_HEIGHT);
            if (it.first_pixel) begin
                in_row = 0;
                in_col = 0;
            end
            if (in_col >= pw)
                in_col = 0;
            line_mem[(in_row % DEF_MAX_KERN_HEIGHT) * DEF_MAX_PAD_WIDTH + in_col] = it.pixel;

            // A window is complete once its bottom-right pixel has arrived.
            if (in_col + 1 >= kw && in_row + 1 >= kh) begin
                col0 = in_col + 1 - kw;
                row0 = in_row + 1 - kh;
                if (col0 < out_width && row0 >= row_start && row0 < row_end) begin
                    acc = 0;
                    for (int r = 0; r < kh; r++)
                        for (int c = 0; c < kw; c++)
                            acc += longint'(line_mem[((row0 + r) % DEF_MAX_KERN_HEIGHT) *
                                                     DEF_MAX_PAD_WIDTH + col0 + c]) *
                                   longint'(coef_mem[r * DEF_MAX_KERN_WIDTH + c]);
                    scaled = acc >>> frac_bits;
                    res.sat = 1'b0;
                    if (scaled > longint'($signed(RESULT_MAX))) begin
                        scaled  = longint'($signed(RESULT_MAX));
                        res.sat = 1'b1;
                    end else if (scaled < longint'($signed(RESULT_MIN))) begin
                        scaled  = longint'($signed(RESULT_MIN));
                        res.sat = 1'b1;
                    end
                    res.value = scaled[RESULT_BITS-1:0];
                    res.row   = row0[OUT_ROW_BITS-1:0];
                    res.col   = col0[OUT_COL_BITS-1:0];
                    pending_results.push_back(res);
                end
            end

            in_col++;
            if (in_col >= pw) begin
                in_col = 0;
                in_row = (in_row + 1) % (1 << IN_ROW_BITS);
            end
        endfunction

        function void check_result(window_result_t got);
            window_result_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer (row %0d, col %0d) with nothing expected",
                       got.row, got.col);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.value !== want.value) begin
                $error("result: expected %0d, actual %0d", $signed(want.value), $signed(got.value));
                mismatch_count++;
            end
            if (got.row !== want.row) begin
                $error("out_row: expected %0d, actual %0d", want.row, got.row);
                mismatch_count++;
            end
            if (got.col !== want.col) begin
                $error("out_col: expected %0d, actual %0d", want.col, got.col);
                mismatch_count++;
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %0d, actual %0d", want.sat, got.sat);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wen;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // tdata from bit 0: coef_index, coef_value, pixel
    logic [IN_DATA_BITS-1:0]   s_axis_tdata;
    // tuser from bit 0: func, first_pixel
    logic [IN_USER_BITS-1:0]   s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // tdata from bit 0: result, out_row, out_col, zero fill
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    // tuser from bit 0: saturated
    logic                      m_axis_tuser;

    corr_scoreboard sb = new();
    bit             quiet;
    bit             rx_hold_req;
    int             rx_hold_left;
    window_result_t seen_result;

    image_2d_correlation_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: check each transfer, then choose the next tready value.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result.value = m_axis_tdata[RESULT_BITS-1:0];
            seen_result.row   = m_axis_tdata[RESULT_BITS +: OUT_ROW_BITS];
            seen_result.col   = m_axis_tdata[RESULT_BITS + OUT_ROW_BITS +: OUT_COL_BITS];
            seen_result.sat   = m_axis_tuser;
            sb.check_result(seen_result);
        end
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    function automatic logic signed [DEF_PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [DEF_COEF_BITS-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 18'sh20000;
            1:       return 18'sh1FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Coefficient item; the pixel fields carry noise that must be ignored.
    function automatic stream_item_t coef_item(int unsigned idx, logic signed [DEF_COEF_BITS-1:0] v);
        stream_item_t it;
        it.func        = FUNC_COEF;
        it.coef_index  = idx;
        it.coef_value  = v;
        it.pixel       = $urandom;
        it.first_pixel = $urandom;
        return it;
    endfunction

    // Pixel item; the coefficient fields carry noise that must be ignored.
    function automatic stream_item_t pixel_item(logic signed [DEF_PIXEL_BITS-1:0] p, logic first);
        stream_item_t it;
        it.func        = FUNC_PIXEL;
        it.coef_index  = $urandom;
        it.coef_value  = $urandom;
        it.pixel       = p;
        it.first_pixel = first;
        return it;
    endfunction

    function automatic int reg_width(logic [CFG_INDEX_BITS-1:0] idx);
        case (idx)
            CFG_PAD_WIDTH:   return PAD_WIDTH_BITS;
            CFG_OUT_WIDTH:   return OUT_WIDTH_BITS;
            CFG_KERN_WIDTH:  return KERN_DIM_BITS;
            CFG_KERN_HEIGHT: return KERN_DIM_BITS;
            CFG_ROW_START:   return ROW_START_BITS;
            CFG_ROW_END:     return ROW_END_BITS;
            CFG_FRAC_BITS:   return FRAC_BITS_BITS;
            default:         return CFG_DATA_BITS;
        endcase
    endfunction

    // One register write; bits above the register width carry noise.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int unsigned value);
        logic [CFG_DATA_BITS-1:0] keep;
        logic [CFG_DATA_BITS-1:0] data;
        keep = (reg_width(idx) >= CFG_DATA_BITS) ? '1 : ((1 << reg_width(idx)) - 1);
        data = ($urandom & ~keep) | (value & keep);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setup(int unsigned pad, int unsigned outw, int unsigned kw,
                               int unsigned kh, int unsigned rs, int unsigned re,
                               int unsigned fb);
        write_reg(CFG_PAD_WIDTH, pad);
        write_reg(CFG_OUT_WIDTH, outw);
        write_reg(CFG_KERN_WIDTH, kw);
        write_reg(CFG_KERN_HEIGHT, kh);
        write_reg(CFG_ROW_START, rs);
        write_reg(CFG_ROW_END, re);
        write_reg(CFG_FRAC_BITS, fb);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, $urandom);
        i_cfg_wen <= 1'b0;
    endtask

    // Offer one item, with random gaps ahead of it, and wait for its transfer.
    task automatic push_item(stream_item_t it);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.pixel, it.coef_value, it.coef_index};
        s_axis_tuser  <= {it.first_pixel, it.func};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
    endtask

    // Stop offering items until every expected result is back, then wait a little more.
    task automatic drain(int extra);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned kw_r, kh_r, kw_e, kh_e, pw_r, pw_e, span, ow, rs, re, fb, rows, npix;
        int          rand_items;
        int          phase_no;
        logic        broken;

        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        quiet         = 1'b0;
        rx_hold_req   = 1'b0;
        rx_hold_left  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole kernel store so that no window ever reads an unwritten tap.
        for (int i = 0; i < KERN_TAPS; i++)
            push_item(coef_item(i, (i == 0) ? 18'sh20000 :
                                   (i == KERN_TAPS - 1) ? 18'sh1FFFF : rand_coef()));
        drain(SETTLE_CYCLES);

        // One-pixel rows with a single tap; zero sizes clamp up to one.
        // Extreme pixels and coefficients saturate in both directions.
        apply_setup(0, 1, 0, 0, 0, 8191, 0);
        push_item(coef_item(0, 18'sh1FFFF));
        push_item(pixel_item(16'sh7FFF, 1'b1));
        push_item(pixel_item(16'sh8000, 1'b0));
        push_item(pixel_item(16'sh0001, 1'b0));
        push_item(coef_item(0, 18'sh20000));
        push_item(pixel_item(16'sh8000, 1'b0));
        push_item(pixel_item(16'sh7FFF, 1'b0));
        push_item(pixel_item(16'sh0000, 1'b0));
        drain(SETTLE_CYCLES);

        // Row window selects a single output row; out_width exceeds what fits;
        // the largest shift; a coefficient write in the middle of the image.
        apply_setup(5, 2047, 3, 2, 1, 2, 31);
        for (int p = 0; p < 15; p++) begin
            if (p == 7)
                push_item(coef_item(1, rand_coef()));
            push_item(pixel_item(rand_pixel(), p == 0));
        end
        drain(SETTLE_CYCLES);

        // Random images under random settings.
        rand_items = 0;
        phase_no   = 0;
        while (rand_items < RANDOM_ITEMS) begin
            phase_no++;
            quiet = (phase_no >= 3 && phase_no <= 5);
            if (phase_no == 1) begin
                // Small kernel so results pile up while the receiver holds off.
                kw_e = 2; kh_e = 2; pw_e = 8; rows = 8;
                apply_setup(pw_e, 7, kw_e, kh_e, 0, 8191, 16);
            end else begin
                kw_r = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) :
                       (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(9, 15));
                kh_r = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) :
                       (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(9, 15));
                kw_e = corr_scoreboard::clip(kw_r, 1, DEF_MAX_KERN_WIDTH);
                kh_e = corr_scoreboard::clip(kh_r, 1, DEF_MAX_KERN_HEIGHT);
                pw_r = ($urandom_range(0, 99) < 8) ? 0 : kw_e + $urandom_range(0, 12);
                pw_e = corr_scoreboard::clip(pw_r, 1, DEF_MAX_PAD_WIDTH);
                span = (pw_e >= kw_e) ? pw_e - kw_e + 1 : 1;
                case ($urandom_range(0, 5))
                    0:       ow = 0;
                    1:       ow = $urandom_range(span, 2047);
                    2:       ow = $urandom_range(1, span);
                    default: ow = span;
                endcase
                rows = kh_e + $urandom_range(0, 3);
                case ($urandom_range(0, 19))
                    0:                 rs = 4095;
                    1, 2, 3, 4, 5:     rs = $urandom_range(0, rows);
                    default:           rs = 0;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: re = 8191;
                    4:          re = 4096;
                    default:    re = $urandom_range(0, rows + 1);
                endcase
                fb = $urandom_range(0, 1) ? $urandom_range(14, 18) : $urandom_range(0, 31);
                apply_setup(pw_r, ow, kw_r, kh_r, rs, re, fb);
            end

            repeat ($urandom_range(0, 4)) begin
                push_item(coef_item($urandom_range(0, KERN_TAPS - 1), rand_coef()));
                rand_items++;
            end
            if (phase_no == 1)
                rx_hold_req = 1'b1;

            npix = rows * pw_e;
            if ($urandom_range(0, 3) == 0)
                npix -= $urandom_range(0, pw_e - 1);
            for (int p = 0; p < npix; p++) begin
                if ($urandom_range(0, 99) < 3) begin
                    push_item(coef_item($urandom_range(0, KERN_TAPS - 1), rand_coef()));
                    rand_items++;
                end
                // A stray start marker restarts the image mid-row.
                broken = (p != 0) && ($urandom_range(0, 99) < 2);
                push_item(pixel_item(rand_pixel(), (p == 0) || broken));
                rand_items++;
                if (phase_no == 2 && p == npix / 2)
                    drain(0);
            end
            drain(SETTLE_CYCLES);
        end

        // Oversized pad width clamps to the longest row; the second row wraps after it.
        quiet = 1'b1;
        apply_setup(2047, 4, 1, 1, 0, 8191, $urandom_range(0, 31));
        for (int p = 0; p < DEF_MAX_PAD_WIDTH + 3; p++)
            push_item(pixel_item(rand_pixel(), p == 0));
        quiet = 1'b0;

        drain(SETTLE_CYCLES);
        if (sb.mismatch_count == 0 && sb.pending_count() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
